FILE: sv/akvt_pkg.sv
// shared types, sizes and codes of the aging key/value table
package akvt_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int KEY_SW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int VAL_SW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_TIMEOUT  = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic [31:0] value_in;
        logic [31:0] now;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [31:0] value_out;
        logic        status;
        logic [4:0]  entry_count;
    } t_out_word;

    // search token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [1:0]        op;
        logic [KEY_SW-1:0] key;
        logic [VAL_SW-1:0] value;
        logic [31:0]       now;
        logic              found;
        logic [IDX_W-1:0]  fidx;
        logic [VAL_SW-1:0] fval;
        logic              dead;
        logic [IDX_W-1:0]  didx;
    } t_tok;

    // slot write broadcast from the controller
    typedef struct packed {
        logic              kv_en;
        logic              val_en;
        logic              st_en;
        logic [IDX_W-1:0]  idx;
        logic [KEY_SW-1:0] key;
        logic [VAL_SW-1:0] value;
        logic [31:0]       stamp;
    } t_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

endpackage

FILE: sv/aging_key_value_table.sv
// top level of the aging key/value table: control, registers and slot chain
//
// input words (operation, key, value_in, now) arrive on a valid/ready channel
// and are taken one at a time. a taken word becomes a search token that walks
// the row of slot cells, one cell per cycle, collecting the first live match
// and the first dead slot among the slots in use. after the last cell the
// controller decides the outcome and writes at most one slot. a new word is
// taken only once the previous one has walked the whole cell row and been
// committed, when the controller is back in idle.
// results sit in an output register; a new word is taken while a result still
// waits, and only the commit step holds until the receiver has taken the
// previous result, so a stalled receiver stops the block after one word.
// configuration goes through an apb port: capacity at 0x0, timeout at 0x4.
// the user must write them only while the block is idle; the block does not enforce it.
// reset (synchronous, active low) empties all slots by clearing the stamps,
// zeroes the entry count, sets capacity to 16 and timeout to 0.
// keys and values of slots never filled are not defined.
module aging_key_value_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  akvt_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output akvt_pkg::t_out_word  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import akvt_pkg::*;

    // control and configuration
    t_state             r_state;
    t_state             n_state;
    logic [4:0]         r_cap;
    logic [15:0]        r_timeout;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   n_used;
    logic [CNT_W-1:0]   w_depth;
    t_tok               r_scan;
    logic               r_out_valid;
    t_out_word          r_out;
    t_out_word          n_out;
    t_wr                w_wr;
    logic               w_accept;
    logic               w_fire;
    logic               w_cfg_wr;
    t_tok               w_tok [ENTRIES+1];
    logic [ENTRIES-1:0] w_tok_valid;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_TIMEOUT) ? {16'd0, r_timeout} : {27'd0, r_cap};

    // zero or oversize capacity means the whole table
    assign w_depth = ((r_cap == 5'd0) || (32'(r_cap) > ENTRIES)) ?
                     CNT_W'(ENTRIES) : CNT_W'(r_cap);

    assign w_accept = i_in_valid && o_in_ready;

    // token injected into the first cell
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = w_accept;
        w_tok[0].op    = i_in_data.operation;
        w_tok[0].key   = i_in_data.key[KEY_SW-1:0];
        w_tok[0].value = i_in_data.value_in[VAL_SW-1:0];
        w_tok[0].now   = i_in_data.now;
    end

    // slot row
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        akvt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_index   (IDX_W'(g)),
            .i_depth   (w_depth),
            .i_timeout (r_timeout),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1]),
            .i_wr      (w_wr)
        );
        assign w_tok_valid[g] = w_tok[g+1].valid;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tok[ENTRIES].valid) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_fire     = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_SCAN:   ;
            ST_COMMIT: w_fire = !r_out_valid || i_out_ready;
            default:   ;
        endcase
    end

    // outcome of a finished scan: result word, slot write, new count
    always_comb begin
        n_out        = '0;
        n_used       = r_used;
        w_wr         = '0;
        w_wr.key     = r_scan.key;
        w_wr.value   = r_scan.value;
        w_wr.stamp   = r_scan.now;
        w_wr.idx     = r_scan.fidx;
        priority if (r_scan.op == OP_LOOKUP) begin
            n_out.hit = r_scan.found;
            if (r_scan.found) begin
                n_out.value_out = 32'(r_scan.fval);
            end
        end else if (r_scan.op == OP_INSERT) begin
            if (r_scan.found) begin
                // refresh a live match
                n_out.hit   = 1'b1;
                w_wr.val_en = w_fire;
                w_wr.st_en  = w_fire;
            end else if ((r_used < w_depth) && r_scan.dead) begin
                // fill the first dead slot
                w_wr.idx    = r_scan.didx;
                w_wr.kv_en  = w_fire;
                w_wr.val_en = w_fire;
                w_wr.st_en  = w_fire;
                n_used      = r_used + CNT_W'(1);
            end else begin
                n_out.status = 1'b1;
            end
        end else if (r_scan.op == OP_DELETE) begin
            if (r_scan.found) begin
                n_out.hit  = 1'b1;
                w_wr.stamp = 32'd0;
                w_wr.st_en = w_fire;
                if (r_used != '0) begin
                    n_used = r_used - CNT_W'(1);
                end
            end
        end else begin
            // unused code leaves everything alone
            n_out.hit = 1'b0;
        end
        n_out.entry_count = 5'(n_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= 5'd16;
            r_timeout   <= 16'd0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                if (paddr[2] == REG_CAPACITY) begin
                    r_cap <= pwdata[4:0];
                end else begin
                    r_timeout <= pwdata[15:0];
                end
            end
            if (w_fire) begin
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN) && w_tok[ENTRIES].valid) begin
            r_scan <= w_tok[ENTRIES];
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_valid) <= 1)
        else $error("more than one token in the slot row");

    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[ENTRIES].valid |-> (r_state == ST_SCAN))
        else $error("token left the row outside a scan");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN) && w_tok[1].valid)
        else $error("accepted word did not enter the row");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= ENTRIES)
        else $error("entry count above table size");

    a_fire_frees_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid && (r_state == ST_IDLE))
        else $error("commit did not present a result");

endmodule

FILE: sv/akvt_cell.sv
// one table slot with its stage of the search chain
module akvt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [akvt_pkg::IDX_W-1:0] i_index,
    input  logic [akvt_pkg::CNT_W-1:0] i_depth,
    input  logic [15:0]          i_timeout,
    input  akvt_pkg::t_tok       i_tok,
    output akvt_pkg::t_tok       o_tok,
    input  akvt_pkg::t_wr        i_wr
);
    import akvt_pkg::*;

    logic [KEY_SW-1:0] r_key;
    logic [VAL_SW-1:0] r_value;
    logic [31:0]       r_stamp;
    t_tok              r_tok;
    t_tok              n_tok;
    logic [32:0]       w_sum;
    logic              w_live;
    logic              w_used;
    logic              w_sel;

    always_comb begin
        w_sum  = {1'b0, r_stamp} + 33'(i_timeout);
        w_live = (r_stamp != 32'd0) &&
                 ((i_timeout == 16'd0) || (w_sum >= {1'b0, i_tok.now}));
        w_used = CNT_W'(i_index) < i_depth;
        w_sel  = i_wr.idx == i_index;
        n_tok  = i_tok;
        if (i_tok.valid && w_used && w_live && !i_tok.found &&
            (r_key == i_tok.key)) begin
            n_tok.found = 1'b1;
            n_tok.fidx  = i_index;
            n_tok.fval  = r_value;
        end
        if (i_tok.valid && w_used && !w_live && !i_tok.dead) begin
            n_tok.dead = 1'b1;
            n_tok.didx = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_stamp <= 32'd0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.st_en && w_sel) begin
                r_stamp <= i_wr.stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.kv_en && w_sel) begin
            r_key <= i_wr.key;
        end
        if (i_wr.val_en && w_sel) begin
            r_value <= i_wr.value;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: tb/aging_key_value_table_test.sv
// self-checking testbench for the aging key/value table
//
// what is tested: lookup, insert/update and delete of the slot table, entry
// expiry against the timeout register, the capacity register (lowered, one
// slot, zero and oversize meaning full depth), full-table insert failures,
// the unused operation code and the count that expiry never lowers.
// how: a scoreboard keeps its own copy of the slot table and predicts every
// result word; result words are compared field by field in order. a short
// table of directed words runs first, then random phases, each with its own
// capacity/timeout setting written over the apb port while the block is idle.
module aging_key_value_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    import akvt_pkg::*;

    localparam int        RESET_CYCLES   = 10;
    localparam int        WATCHDOG_LIMIT = 4000;
    localparam int        SETTLE_CYCLES  = ENTRIES + 4;
    localparam int        PHASE_WORDS    = 215;
    localparam int        PHASES         = 7;
    localparam int        POOL_KEYS      = 12;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    // register setting of each random phase: extremes of both registers,
    // zero and oversize capacity (both mean full depth)
    localparam logic [4:0]  PHASE_CAPACITY [PHASES] = '{5'd16, 5'd1, 5'd4, 5'd0,
                                                        5'd8, 5'd31, 5'd16};
    localparam logic [15:0] PHASE_TIMEOUT  [PHASES] = '{16'd0, 16'd0, 16'd0, 16'd0,
                                                        16'd65535, 16'd3, 16'd1};

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_CAPACITY,
        ROW_TIMEOUT
    } t_row_kind;

    // one line of the directed table
    typedef struct {
        t_row_kind   kind;
        t_in_word    word;
        bit          pinned;
        t_out_word   result;
        logic [31:0] reg_value;
    } t_stim_row;

    // result typed into the directed table, travels with its word
    typedef struct {
        bit        pinned;
        t_out_word result;
    } t_pinned_result;

    // ports of the block
    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // scoreboard copy of the slot table and its registers
    logic [31:0] tbl_key   [ENTRIES];
    logic [31:0] tbl_value [ENTRIES];
    logic [31:0] tbl_stamp [ENTRIES];
    logic [4:0]  tbl_count;
    logic [4:0]  cfg_capacity;
    logic [15:0] cfg_timeout;

    t_out_word      replies_due [$];
    t_pinned_result pinned_results [$];

    int          mismatches   = 0;
    int          stall_cycles = 0;
    bit          quiet_stretch = 1'b0;
    logic [31:0] run_clock;
    logic [31:0] key_pool [POOL_KEYS];

    aging_key_value_table DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // slot table predictor
    // ---------------------------------------------------------------

    // slots scanned: zero or oversize capacity means all of them
    function automatic int scan_depth();
        if (cfg_capacity == 0 || cfg_capacity > ENTRIES) return ENTRIES;
        return int'(cfg_capacity);
    endfunction

    // live: stamped, and not past stamp + timeout (33-bit sum, no wrap)
    function automatic bit slot_live(int i, logic [31:0] t);
        logic [32:0] limit;
        limit = {1'b0, tbl_stamp[i]} + 33'(cfg_timeout);
        return (tbl_stamp[i] != '0) && (cfg_timeout == '0 || limit >= {1'b0, t});
    endfunction

    // first live slot holding the key, ENTRIES when none
    function automatic int live_match(logic [31:0] key, logic [31:0] t);
        int depth;
        depth = scan_depth();
        for (int i = 0; i < depth; i++) begin
            if (slot_live(i, t) && tbl_key[i] == key) return i;
        end
        return ENTRIES;
    endfunction

    // applies one word to the table copy and returns the reply it owes
    function automatic t_out_word table_apply(t_in_word w);
        t_out_word r;
        int        slot;
        int        depth;
        bit        placed;
        r      = '0;
        placed = 1'b0;
        slot   = live_match(w.key, w.now);
        case (w.operation)
            OP_LOOKUP: begin
                if (slot < ENTRIES) begin
                    r.hit       = 1'b1;
                    r.value_out = tbl_value[slot];
                end
            end
            OP_INSERT: begin
                if (slot < ENTRIES) begin
                    // update of a live match restamps it
                    r.hit           = 1'b1;
                    tbl_value[slot] = w.value_in;
                    tbl_stamp[slot] = w.now;
                end else begin
                    // fill the first dead slot unless the count says full
                    depth    = scan_depth();
                    r.status = 1'b1;
                    if (int'(tbl_count) < depth) begin
                        for (int i = 0; i < depth && !placed; i++) begin
                            if (!slot_live(i, w.now)) begin
                                tbl_key[i]   = w.key;
                                tbl_value[i] = w.value_in;
                                tbl_stamp[i] = w.now;
                                tbl_count    = tbl_count + 5'd1;
                                r.status     = 1'b0;
                                placed       = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_DELETE: begin
                if (slot < ENTRIES) begin
                    r.hit           = 1'b1;
                    tbl_stamp[slot] = '0;
                    // count saturates at zero
                    if (tbl_count != '0) tbl_count = tbl_count - 5'd1;
                end
            end
            default: ;
        endcase
        r.entry_count = tbl_count;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // scoreboard and receiver
    // ---------------------------------------------------------------

    // result words are checked before the word taken at the same edge is
    // predicted; a result never belongs to a word taken at that same edge
    always @(posedge i_clk) begin : scoreboard
        t_out_word      want;
        t_pinned_result tag;
        bit             took;
        took = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                took = 1'b1;
                if (replies_due.size() == 0) begin
                    $error("result word with no word outstanding: %p", o_out_data);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_out_data.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_out_data.hit);
                        mismatches++;
                    end
                    if (o_out_data.value_out !== want.value_out) begin
                        $error("value_out: expected %h, got %h",
                               want.value_out, o_out_data.value_out);
                        mismatches++;
                    end
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, o_out_data.status);
                        mismatches++;
                    end
                    if (o_out_data.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, o_out_data.entry_count);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                took = 1'b1;
                tag  = pinned_results.pop_front();
                // the table copy always advances; a typed-in result wins
                want = table_apply(i_in_data);
                if (tag.pinned) want = tag.result;
                replies_due.push_back(want);
            end
        end
        stall_cycles <= took ? 0 : stall_cycles + 1;
        // receiver stalls at a rate of about 13 in 100, never in the quiet stretch
        i_out_ready  <= quiet_stretch || ($urandom_range(99) >= 13);
    end

    // no word moving on either channel for too long
    always @(posedge i_clk) begin
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("aging_key_value_table_test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sender and register access
    // ---------------------------------------------------------------

    // offers one word, returns at the edge that takes it; valid stays up
    // so a following word goes out back to back unless a gap is drawn
    task automatic send_word(t_in_word w, bit pinned, t_out_word result);
        t_pinned_result tag;
        tag.pinned = pinned;
        tag.result = result;
        pinned_results.push_back(tag);
        if (!quiet_stretch && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // drop valid and wait until every owed result word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    // apb write followed by a read back of the same register
    task automatic reg_write(logic [2:0] addr, logic [31:0] data, logic [31:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // read setup, psel stays high
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & mask) !== (data & mask)) begin
            $error("register at %h: expected %h, got %h", addr, data & mask, prdata & mask);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == {REG_CAPACITY, 2'b00}) cfg_capacity = data[4:0];
        else cfg_timeout = data[15:0];
    endtask

    task automatic set_capacity(logic [4:0] cap);
        reg_write({REG_CAPACITY, 2'b00}, 32'(cap), 32'h0000_001f);
    endtask

    task automatic set_timeout(logic [15:0] tmo);
        reg_write({REG_TIMEOUT, 2'b00}, 32'(tmo), 32'h0000_ffff);
    endtask

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    function automatic t_stim_row word_row(logic [1:0] op, logic [31:0] key,
                                           logic [31:0] value, logic [31:0] t);
        t_stim_row r;
        r           = '{kind: ROW_WORD, default: '0};
        r.word      = '{operation: op, key: key, value_in: value, now: t};
        return r;
    endfunction

    // word whose result is plain to see, typed in here
    function automatic t_stim_row pinned_row(logic [1:0] op, logic [31:0] key,
                                             logic [31:0] value, logic [31:0] t,
                                             logic hit, logic [31:0] vout,
                                             logic status, logic [4:0] count);
        t_stim_row r;
        r        = word_row(op, key, value, t);
        r.pinned = 1'b1;
        r.result = '{hit: hit, value_out: vout, status: status, entry_count: count};
        return r;
    endfunction

    function automatic t_stim_row reg_row(t_row_kind kind, logic [31:0] value);
        t_stim_row r;
        r           = '{kind: kind, default: '0};
        r.reg_value = value;
        return r;
    endfunction

    // random word: mostly pool keys so entries get found again, time mostly
    // creeping forward so expiry happens, now and then anything at all
    function automatic t_in_word random_word();
        t_in_word    w;
        int unsigned pick;
        logic [31:0] t;
        pick = $urandom_range(99);
        if (pick < 35)      w.operation = OP_LOOKUP;
        else if (pick < 75) w.operation = OP_INSERT;
        else if (pick < 95) w.operation = OP_DELETE;
        else                w.operation = OP_UNUSED;
        w.key      = ($urandom_range(99) < 96) ? key_pool[$urandom_range(POOL_KEYS - 1)]
                                               : $urandom;
        w.value_in = $urandom;
        if ($urandom_range(99) < 92) begin
            run_clock = run_clock + $urandom_range(0, 2);
            w.now     = run_clock;
        end else begin
            do t = $urandom; while (t == '0);
            w.now = t;
        end
        return w;
    endfunction

    initial begin : stimulus
        t_stim_row directed_rows [$];
        t_stim_row row;
        t_in_word  w;

        // empty table, registers at their reset values
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
            tbl_stamp[i] = '0;
        end
        tbl_count    = '0;
        cfg_capacity = 5'd16;
        cfg_timeout  = '0;
        run_clock    = 32'd100;
        key_pool[0]  = 32'h0000_0000;
        key_pool[1]  = 32'hffff_ffff;
        for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = $urandom;

        // directed table; comments give the slot contents as they evolve
        // misses on an empty table, delete saturates the count at zero
        directed_rows.push_back(pinned_row(OP_LOOKUP, 32'h0, 32'h0, 32'd1, 0, 32'h0, 0, 5'd0));
        directed_rows.push_back(pinned_row(OP_DELETE, '1, 32'h0, 32'd1, 0, 32'h0, 0, 5'd0));
        // slot 0: key 0, slot 1: all-ones key at the latest time
        directed_rows.push_back(pinned_row(OP_INSERT, 32'h0, '1, 32'd1, 0, 32'h0, 0, 5'd1));
        directed_rows.push_back(pinned_row(OP_LOOKUP, 32'h0, 32'h0, '1, 1, '1, 0, 5'd1));
        directed_rows.push_back(pinned_row(OP_INSERT, '1, 32'h0, '1, 0, 32'h0, 0, 5'd2));
        // update of a live match
        directed_rows.push_back(pinned_row(OP_INSERT, 32'h0, 32'h1234_5678, 32'd2,
                                           1, 32'h0, 0, 5'd2));
        directed_rows.push_back(pinned_row(OP_LOOKUP, 32'h0, 32'h0, 32'd3,
                                           1, 32'h1234_5678, 0, 5'd2));
        // unused operation code leaves everything alone
        directed_rows.push_back(pinned_row(OP_UNUSED, 32'h0, '1, 32'd3, 0, 32'h0, 0, 5'd2));
        // stamped at time zero: counted but never live
        directed_rows.push_back(pinned_row(OP_INSERT, 32'h5, 32'haaaa_5555, 32'd0,
                                           0, 32'h0, 0, 5'd3));
        directed_rows.push_back(pinned_row(OP_LOOKUP, 32'h5, 32'h0, 32'd5, 0, 32'h0, 0, 5'd3));
        directed_rows.push_back(pinned_row(OP_DELETE, 32'h0, 32'h0, 32'd6, 1, 32'h0, 0, 5'd2));
        directed_rows.push_back(pinned_row(OP_LOOKUP, 32'h0, 32'h0, 32'd6, 0, 32'h0, 0, 5'd2));
        // refills go to the first dead slot
        directed_rows.push_back(word_row(OP_INSERT, 32'h7, 32'h5555_5555, 32'd4));
        directed_rows.push_back(word_row(OP_DELETE, '1, 32'h0, 32'd9));
        directed_rows.push_back(word_row(OP_INSERT, 32'h5, 32'h1, 32'd9));
        // capacity lowered below the count: a new key cannot go in
        directed_rows.push_back(reg_row(ROW_CAPACITY, 32'd2));
        directed_rows.push_back(pinned_row(OP_INSERT, 32'h9, 32'h9, 32'd10, 0, 32'h0, 1, 5'd3));
        // expiry boundary: live at stamp + timeout, dead one later
        directed_rows.push_back(reg_row(ROW_TIMEOUT, 32'd5));
        directed_rows.push_back(word_row(OP_LOOKUP, 32'h7, 32'h0, 32'd9));
        directed_rows.push_back(word_row(OP_LOOKUP, 32'h7, 32'h0, 32'd10));
        // expired entries still hold the count, insert fails
        directed_rows.push_back(word_row(OP_INSERT, 32'h7, 32'h2, 32'd10));
        // oversize capacity means full depth, longest timeout
        directed_rows.push_back(reg_row(ROW_CAPACITY, 32'd31));
        directed_rows.push_back(reg_row(ROW_TIMEOUT, 32'd65535));
        directed_rows.push_back(word_row(OP_INSERT, 32'h7, 32'h3, 32'd20));
        directed_rows.push_back(word_row(OP_LOOKUP, 32'h5, 32'h0, 32'd65544));
        directed_rows.push_back(word_row(OP_DELETE, 32'h5, 32'h0, 32'd65545));
        directed_rows.push_back(word_row(OP_INSERT, 32'hffff_fffe, 32'h8000_0001, 32'hffff_0000));
        directed_rows.push_back(word_row(OP_LOOKUP, 32'hffff_fffe, 32'h0, 32'hffff_ffff));

        // synchronous reset, held for a while
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            case (row.kind)
                ROW_WORD: begin
                    send_word(row.word, row.pinned, row.result);
                end
                ROW_CAPACITY: begin
                    drain();
                    set_capacity(row.reg_value[4:0]);
                end
                default: begin
                    drain();
                    set_timeout(row.reg_value[15:0]);
                end
            endcase
        end

        // random phases, registers rewritten only with nothing in flight
        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_capacity(PHASE_CAPACITY[p]);
            set_timeout(PHASE_TIMEOUT[p]);
            // one whole phase without any gaps on either side
            quiet_stretch = (p == 3);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w = random_word();
                send_word(w, 1'b0, '0);
                // sender holds off until every owed result is back
                if (n % 100 == 50) drain();
            end
        end
        quiet_stretch = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("aging_key_value_table_test passed");
        end else begin
            $display("aging_key_value_table_test failed");
        end
        $finish;
    end

endmodule
